### rtl/sf3_pkg.sv
// Shared constants and types of the 3x3 sharpen filter.
package sf3_pkg;

   localparam int PIXEL_BITS    = 8;
   localparam int WIDTH_BITS    = 11;
   localparam int HEIGHT_BITS   = 13;
   localparam int LEVEL_BITS    = 4;
   localparam int COUNT_BITS    = 23;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 13;
   localparam int SUM_BITS      = 14;
   localparam int PROD_BITS     = SUM_BITS + LEVEL_BITS + 1;
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHARPEN_LEVEL = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // One classified request handed from front to back.
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [WIDTH_BITS-1:0] col;
      logic                  emit;
      logic                  filt;
      logic                  last;
      logic [LEVEL_BITS-1:0] level;
   } sf3_item_type;

endpackage

### rtl/sf3_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module sf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/sf3_div.sv
// Bit-serial divider: remainder of one dividend, quotient and remainder of another.
module sf3_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [sf3_pkg::WIDTH_BITS-1:0]   divisor,
   input  logic [sf3_pkg::COUNT_BITS-1:0]   dividend_a,
   input  logic [sf3_pkg::COUNT_BITS-1:0]   dividend_b,
   output logic                             busy,
   output logic                             done,
   output logic [sf3_pkg::WIDTH_BITS-1:0]   rem_a,
   output logic [sf3_pkg::COUNT_BITS-1:0]   quot_b,
   output logic [sf3_pkg::WIDTH_BITS-1:0]   rem_b
);

   localparam int CB = sf3_pkg::COUNT_BITS;
   localparam int WB = sf3_pkg::WIDTH_BITS;
   localparam int SB = $clog2(CB);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [SB-1:0] step_ff, step_in;
   logic [WB-1:0] dv_ff, dv_in;
   logic [WB-1:0] ra_ff, ra_in;
   logic [WB-1:0] rb_ff, rb_in;
   logic [CB-1:0] qa_ff, qa_in;
   logic [CB-1:0] qb_ff, qb_in;
   logic [WB:0]   ta, tb;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dv_in   = dv_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      qa_in   = qa_ff;
      qb_in   = qb_ff;
      ta      = {ra_ff, qa_ff[CB-1]};
      tb      = {rb_ff, qb_ff[CB-1]};
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         dv_in   = divisor;
         ra_in   = '0;
         rb_in   = '0;
         qa_in   = dividend_a;
         qb_in   = dividend_b;
      end else if (run_ff) begin
         qa_in = {qa_ff[CB-2:0], 1'b0};
         if (ta >= {1'b0, dv_ff}) begin
            ra_in = WB'(ta - {1'b0, dv_ff});
         end else begin
            ra_in = ta[WB-1:0];
         end
         if (tb >= {1'b0, dv_ff}) begin
            rb_in = WB'(tb - {1'b0, dv_ff});
            qb_in = {qb_ff[CB-2:0], 1'b1};
         end else begin
            rb_in = tb[WB-1:0];
            qb_in = {qb_ff[CB-2:0], 1'b0};
         end
         step_in = SB'(step_ff + 1'b1);
         if (step_ff == SB'(CB - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dv_ff <= dv_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      qa_ff <= qa_in;
      qb_ff <= qb_in;
   end

   assign busy   = run_ff;
   assign done   = done_ff;
   assign rem_a  = ra_ff;
   assign quot_b = qb_ff;
   assign rem_b  = rb_ff;

endmodule

### rtl/sf3_fifo.sv
// Short queue of classified requests between front and back.
module sf3_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sf3_pkg::sf3_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output sf3_pkg::sf3_item_type head
);

   localparam int D  = sf3_pkg::QUEUE_DEPTH;
   localparam int PB = $clog2(D);

   sf3_pkg::sf3_item_type mem_ff [D];
   logic [PB-1:0] wptr_ff, wptr_in;
   logic [PB-1:0] rptr_ff, rptr_in;
   logic [PB:0]   count_ff, count_in;

   always_comb begin
      wptr_in  = push ? PB'(wptr_ff + 1'b1) : wptr_ff;
      rptr_in  = pop ? PB'(rptr_ff + 1'b1) : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = (PB+1)'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = (PB+1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == (PB+1)'(D));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rptr_ff];

endmodule

### rtl/sf3_front.sv
// Front: configuration registers, frame counters and request classification.
module sf3_front #(
   parameter int MAX_WIDTH = sf3_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sf3_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [sf3_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,
   input  logic [sf3_pkg::PIXEL_BITS-1:0]      req_tdata,
   input  logic                                queue_full,
   output logic                                push,
   output sf3_pkg::sf3_item_type               push_item
);

   localparam int WB = sf3_pkg::WIDTH_BITS;
   localparam int HB = sf3_pkg::HEIGHT_BITS;
   localparam int LB = sf3_pkg::LEVEL_BITS;
   localparam int CB = sf3_pkg::COUNT_BITS;
   localparam logic [WB+1:0] MaxW = (WB+2)'(MAX_WIDTH);

   logic [WB-1:0] width_ff, width_in;
   logic [HB-1:0] height_ff, height_in;
   logic [LB-1:0] level_ff, level_in;
   logic [CB-1:0] total_ff;
   logic          pend_ff;
   logic [CB-1:0] taken_ff, taken_in;
   logic [WB-1:0] col_ff, col_in;
   logic [CB-1:0] given_ff, given_in;
   logic [CB-1:0] qr_ff, qr_in;
   logic [WB-1:0] qc_ff, qc_in;

   logic [WB-1:0] eff_w;
   logic [HB-1:0] eff_h;
   logic          csr_wr, acc, full_taken, keep, emit, last, filt, busy;
   logic          div_busy, div_done;
   logic [WB-1:0] div_rem_a, div_rem_b;
   logic [CB-1:0] div_quot_b;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WB'(1);
      end else if ({2'b00, width_ff} > MaxW) begin
         eff_w = MaxW[WB-1:0];
      end else begin
         eff_w = width_ff;
      end
      eff_h = (height_ff == '0) ? HB'(1) : height_ff;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      level_in  = level_ff;
      if (csr_wr) begin
         case (csr_index)
            sf3_pkg::REG_FRAME_WIDTH:   width_in  = csr_data[WB-1:0];
            sf3_pkg::REG_FRAME_HEIGHT:  height_in = csr_data[HB-1:0];
            sf3_pkg::REG_SHARPEN_LEVEL: level_in  = csr_data[LB-1:0];
            default: ;
         endcase
      end
   end

   // Counters are re-derived for the new width before requests resume.
   sf3_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (pend_ff),
      .divisor    (eff_w),
      .dividend_a (taken_ff),
      .dividend_b (given_ff),
      .busy       (div_busy),
      .done       (div_done),
      .rem_a      (div_rem_a),
      .quot_b     (div_quot_b),
      .rem_b      (div_rem_b)
   );

   assign busy       = pend_ff || div_busy || div_done;
   assign req_tready = !queue_full && !busy;
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      full_taken = (taken_ff >= total_ff);
      keep       = full_taken || (req_tuser == sf3_pkg::OP_PIXEL);
      emit       = (taken_ff >= CB'(eff_w) + CB'(1));
      last       = (CB'(given_ff + 1'b1) >= total_ff);
      filt       = (level_ff != '0) && (qr_ff != '0)
                   && ({1'b0, qr_ff} + (CB+1)'(1) < (CB+1)'(eff_h))
                   && (qc_ff != '0)
                   && ({1'b0, qc_ff} + (WB+1)'(1) < {1'b0, eff_w});

      push            = acc && keep;
      push_item.pixel = full_taken ? '0 : req_tdata;
      push_item.col   = col_ff;
      push_item.emit  = emit;
      push_item.filt  = filt;
      push_item.last  = last;
      push_item.level = level_ff;

      taken_in = taken_ff;
      col_in   = col_ff;
      given_in = given_ff;
      qr_in    = qr_ff;
      qc_in    = qc_ff;
      if (div_done) begin
         col_in = div_rem_a;
         qr_in  = div_quot_b;
         qc_in  = div_rem_b;
      end else if (push) begin
         taken_in = CB'(taken_ff + 1'b1);
         col_in   = (WB'(col_ff + 1'b1) == eff_w) ? '0 : WB'(col_ff + 1'b1);
         if (emit) begin
            given_in = CB'(given_ff + 1'b1);
            if (WB'(qc_ff + 1'b1) == eff_w) begin
               qc_in = '0;
               qr_in = CB'(qr_ff + 1'b1);
            end else begin
               qc_in = WB'(qc_ff + 1'b1);
            end
            if (last) begin
               taken_in = '0;
               col_in   = '0;
               given_in = '0;
               qr_in    = '0;
               qc_in    = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WB'(1);
         height_ff <= HB'(1);
         level_ff  <= '0;
         total_ff  <= CB'(1);
         pend_ff   <= 1'b0;
         taken_ff  <= '0;
         col_ff    <= '0;
         given_ff  <= '0;
         qr_ff     <= '0;
         qc_ff     <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         level_ff  <= level_in;
         total_ff  <= CB'(eff_w) * CB'(eff_h);
         pend_ff   <= csr_wr;
         taken_ff  <= taken_in;
         col_ff    <= col_in;
         given_ff  <= given_in;
         qr_ff     <= qr_in;
         qc_ff     <= qc_in;
      end
   end

endmodule

### rtl/sf3_back.sv
// Back: row stores, 3x3 window, kernel sum and scale/clamp into the output register.
module sf3_back #(
   parameter int MAX_WIDTH = sf3_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           item_valid,
   input  sf3_pkg::sf3_item_type          item,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sf3_pkg::PIXEL_BITS-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int PB = sf3_pkg::PIXEL_BITS;
   localparam int WB = sf3_pkg::WIDTH_BITS;
   localparam int SB = sf3_pkg::SUM_BITS;
   localparam int MB = sf3_pkg::PROD_BITS;
   localparam int AW = $clog2(MAX_WIDTH);

   logic                  adv;
   logic                  b_valid_ff;
   sf3_pkg::sf3_item_type b_item_ff;
   logic                  c_valid_ff;
   sf3_pkg::sf3_item_type c_item_ff;
   logic                  d_valid_ff;
   sf3_pkg::sf3_item_type d_item_ff;
   logic signed [SB-1:0]  d_sum_ff, sum;
   logic [PB-1:0]         d_mid_ff;
   logic [PB-1:0]         window_ff [9];
   logic [PB-1:0]         window_in [9];
   logic                  fwd_valid_ff;
   logic [WB-1:0]         fwd_col_ff;
   logic [PB-1:0]         fwd_up_ff, fwd_mid_ff;
   logic [PB-1:0]         up_ram, mid_ram, up_rd, mid_rd;
   logic                  wr;
   logic                  rsp_valid_ff;
   logic [PB-1:0]         rsp_data_ff, pix;
   logic                  rsp_last_ff;
   logic [PB+4:0]         center;
   logic [PB+1:0]         edge_sum, corner_sum;
   logic signed [MB-1:0]  prod;

   assign adv = !rsp_valid_ff || rsp_tready;
   assign pop = adv && item_valid;
   assign wr  = adv && b_valid_ff;

   sf3_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_upper (
      .clock (clock),
      .we    (wr),
      .waddr (AW'(b_item_ff.col)),
      .wdata (mid_rd),
      .re    (pop),
      .raddr (AW'(item.col)),
      .rdata (up_ram)
   );

   sf3_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_middle (
      .clock (clock),
      .we    (wr),
      .waddr (AW'(b_item_ff.col)),
      .wdata (b_item_ff.pixel),
      .re    (pop),
      .raddr (AW'(item.col)),
      .rdata (mid_ram)
   );

   // Last write wins; covers a read issued in the same cycle as that write.
   always_comb begin
      if (fwd_valid_ff && fwd_col_ff == b_item_ff.col) begin
         up_rd  = fwd_up_ff;
         mid_rd = fwd_mid_ff;
      end else begin
         up_rd  = up_ram;
         mid_rd = mid_ram;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         window_in[r*3]   = window_ff[r*3+1];
         window_in[r*3+1] = window_ff[r*3+2];
      end
      window_in[2] = up_rd;
      window_in[5] = mid_rd;
      window_in[8] = b_item_ff.pixel;
   end

   // 28*center - 2*edges - corners
   always_comb begin
      center     = (PB+5)'({window_ff[4], 4'b0000}) + (PB+5)'({window_ff[4], 3'b000})
                   + (PB+5)'({window_ff[4], 2'b00});
      edge_sum   = (PB+2)'(window_ff[1]) + (PB+2)'(window_ff[3])
                   + (PB+2)'(window_ff[5]) + (PB+2)'(window_ff[7]);
      corner_sum = (PB+2)'(window_ff[0]) + (PB+2)'(window_ff[2])
                   + (PB+2)'(window_ff[6]) + (PB+2)'(window_ff[8]);
      sum        = $signed({1'b0, center}) - $signed({3'b000, edge_sum, 1'b0})
                   - $signed({4'b0000, corner_sum});
   end

   always_comb begin
      prod = MB'(d_sum_ff) * MB'($signed({1'b0, d_item_ff.level}));
      if (!d_item_ff.filt) begin
         pix = d_mid_ff;
      end else if (prod[MB-1]) begin
         pix = '0;
      end else if (prod[MB-2:PB+4] != '0) begin
         pix = '1;
      end else begin
         pix = prod[PB+3:4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else if (adv) begin
         b_valid_ff   <= item_valid;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         rsp_valid_ff <= d_valid_ff && d_item_ff.emit;
         if (b_valid_ff) begin
            fwd_valid_ff <= 1'b1;
            for (int i = 0; i < 9; i++) begin
               window_ff[i] <= window_in[i];
            end
         end
      end
      if (adv) begin
         b_item_ff   <= item;
         c_item_ff   <= b_item_ff;
         d_item_ff   <= c_item_ff;
         d_sum_ff    <= sum;
         d_mid_ff    <= window_ff[4];
         rsp_data_ff <= pix;
         rsp_last_ff <= d_item_ff.last;
         if (b_valid_ff) begin
            fwd_col_ff <= b_item_ff.col;
            fwd_up_ff  <= mid_rd;
            fwd_mid_ff <= b_item_ff.pixel;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/sharpen_filter_3x3.sv
// Top level of the streaming 3x3 sharpen filter for 8-bit gray frames.
//
//   channel   direction  payload
//   req_*     in         tuser: op (0 pixel, 1 drain); tdata: pixel_in
//   rsp_*     out        tdata: pixel_out; tlast: frame_end
//   csr_*     in         index: 0 frame_width, 1 frame_height, 2 sharpen_level
//
// One request per clock unless a full queue or a register write holds req_tready
// low; a result leaves after the request that releases it, through the row-store
// read, window, kernel sum and scale stages. A register write holds req_tready low
// while the divider re-derives column and row counters, one quotient bit per cycle.
// Synchronous reset restores the register defaults; the row stores are not cleared.
// A stalled rsp side backs up through a four-entry request queue.
module sharpen_filter_3x3 #(
   parameter int MAX_WIDTH = sf3_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,   // op
   input  logic [sf3_pkg::PIXEL_BITS-1:0]      req_tdata,   // pixel_in
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sf3_pkg::PIXEL_BITS-1:0]      rsp_tdata,   // pixel_out
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sf3_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [sf3_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   logic                  push, queue_full, pop, not_empty;
   sf3_pkg::sf3_item_type push_item, head;

   sf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   sf3_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   sf3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (not_empty),
      .item       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
